// ===== sv/lsef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsef_pkg
// Shared types and constants of the labeled segment endpoint finder.
// ----------------------------------------------------------------------------
package lsef_pkg;

    localparam int LABEL_W        = 12;
    localparam int INDEX_W        = 20;
    localparam int MASK_W         = 8;
    localparam int COUNT_W        = 4;
    localparam int RING_SIZE      = 8;
    localparam int MAX_LABELS_DEF = 4096;

    // Epoch tag held per store entry; the all-ones tag marks a cleared entry.
    localparam int                 EPOCH_W    = 8;
    localparam logic [EPOCH_W-1:0] CLEAR_TAG  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_WRAP = CLEAR_TAG - EPOCH_W'(1);

    typedef enum logic {
        SW_IDLE,
        SW_CLEAR
    } t_sweep_state;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               endpoint;
    } t_ring_result;

endpackage
`default_nettype wire

// ===== sv/lsef_ring_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsef_ring_count
// Counts inside 8-neighbors matching the nonzero center label.
// ----------------------------------------------------------------------------
module lsef_ring_count (
    input  wire logic [lsef_pkg::LABEL_W-1:0]                          i_center,
    input  wire logic [lsef_pkg::RING_SIZE-1:0][lsef_pkg::LABEL_W-1:0] i_neighbors,
    input  wire logic [lsef_pkg::MASK_W-1:0]                           i_inside,
    output lsef_pkg::t_ring_result                                     o_result
);

    logic [lsef_pkg::RING_SIZE-1:0] w_match;
    logic [lsef_pkg::COUNT_W-1:0]   w_count;

    always_comb begin
        for (int k = 0; k < lsef_pkg::RING_SIZE; k++) begin
            w_match[k] = i_inside[k] && (i_neighbors[k] == i_center);
        end
    end

    always_comb begin
        w_count = '0;
        if (i_center != '0) begin
            for (int k = 0; k < lsef_pkg::RING_SIZE; k++) begin
                w_count = w_count + lsef_pkg::COUNT_W'(w_match[k]);
            end
        end
    end

    assign o_result.count    = w_count;
    assign o_result.endpoint = (w_count == lsef_pkg::COUNT_W'(1));

endmodule
`default_nettype wire

// ===== sv/lsef_seen_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsef_seen_store
// Per-label epoch tag memory with registered read, write forwarding and a
// clearing sweep after reset and on request.
// ----------------------------------------------------------------------------
module lsef_seen_store #(
    parameter int MAX_LABELS = lsef_pkg::MAX_LABELS_DEF,
    parameter int AW         = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_addr,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [lsef_pkg::EPOCH_W-1:0] i_wr_tag,
    input  wire logic                         i_sweep_start,
    output logic [lsef_pkg::EPOCH_W-1:0]      o_rd_tag,
    output logic                              o_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LABELS - 1);

    logic [lsef_pkg::EPOCH_W-1:0] r_mem [MAX_LABELS];

    lsef_pkg::t_sweep_state       r_state, n_state;
    logic [AW-1:0]                r_sweep_addr, n_sweep_addr;
    logic [lsef_pkg::EPOCH_W-1:0] r_rd_data;
    logic [AW-1:0]                r_rd_addr;
    logic                         r_fw_vld;
    logic [AW-1:0]                r_fw_addr;
    logic [lsef_pkg::EPOCH_W-1:0] r_fw_tag;

    logic                         w_we;
    logic [AW-1:0]                w_wa;
    logic [lsef_pkg::EPOCH_W-1:0] w_wd;

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        unique case (r_state)
            lsef_pkg::SW_IDLE: begin
                if (i_sweep_start) begin
                    n_state      = lsef_pkg::SW_CLEAR;
                    n_sweep_addr = '0;
                end
            end
            lsef_pkg::SW_CLEAR: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (r_sweep_addr == LAST_ADDR) begin
                    n_state = lsef_pkg::SW_IDLE;
                end
            end
            default: begin
                n_state = lsef_pkg::SW_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsef_pkg::SW_CLEAR;
            r_sweep_addr <= '0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
        end
    end

    assign o_busy = (r_state == lsef_pkg::SW_CLEAR);
    assign w_we   = o_busy || i_wr_en;
    assign w_wa   = o_busy ? r_sweep_addr : i_wr_addr;
    assign w_wd   = o_busy ? lsef_pkg::CLEAR_TAG : i_wr_tag;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_fw_addr <= i_wr_addr;
            r_fw_tag  <= i_wr_tag;
        end
    end

    // forward a write that lands on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_fw_vld <= i_wr_en;
        end
    end

    assign o_rd_tag = (r_fw_vld && (r_fw_addr == r_rd_addr)) ? r_fw_tag : r_rd_data;

endmodule
`default_nettype wire

// ===== sv/labeled_segment_endpoint_finder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// labeled_segment_endpoint_finder_core
// Flags segment endpoints in a labeled pixel stream and marks the first
// endpoint of each label per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per item: center label, the eight neighbor
//   labels (W,E,N,S,NW,NE,SW,SE), inside mask and raster index in tdata,
//   frame start in tuser. m_axis returns one result item per pixel: label,
//   index, same-label count, endpoint and first-endpoint flags.
//   Throughput is one item per cycle while m_axis_tready is high and no
//   sweep runs; each item passes the read stage and the output register.
//   The per-label seen store is one memory of epoch tags read on accept
//   and written back as the item enters the output register, with a
//   forwarding register for back-to-back hits on the same label. After
//   reset the store is swept through all MAX_LABELS entries with
//   s_axis_tready low. A frame start advances the epoch; once every 255
//   frames the epoch wraps and the frame-start item waits for the read
//   stage to drain and a full sweep to end before it is taken.
//   When m_axis_tready is low the output item holds, one more item can wait
//   in the read stage, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module labeled_segment_endpoint_finder_core #(
    parameter int MAX_LABELS = lsef_pkg::MAX_LABELS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // center, west, east, north, south, northwest, northeast, southwest,
    // southeast labels, inside_mask, pixel_index
    input  wire logic [135:0] s_axis_tdata,
    // frame_start
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_label, out_index, same_label_count, is_endpoint, first_endpoint,
    // two zero pad bits
    output logic [39:0]       m_axis_tdata
);

    localparam int AW       = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int LW       = lsef_pkg::LABEL_W;
    localparam int IW       = lsef_pkg::INDEX_W;
    localparam int CW       = lsef_pkg::COUNT_W;
    localparam int EW       = lsef_pkg::EPOCH_W;
    localparam int NB_LO    = LW;
    localparam int MASK_LO  = LW * (lsef_pkg::RING_SIZE + 1);
    localparam int INDEX_LO = MASK_LO + lsef_pkg::MASK_W;
    localparam int OUT_W    = LW + IW + CW + 2;

    logic [LW-1:0]                               w_center;
    logic [lsef_pkg::RING_SIZE-1:0][LW-1:0]      w_neighbors;
    logic [lsef_pkg::MASK_W-1:0]                 w_inside;
    logic [IW-1:0]                               w_index;
    logic                                        w_frame_start;
    lsef_pkg::t_ring_result                      w_ring;
    logic [31:0]                                 w_label_ext;
    logic [AW-1:0]                               w_rd_addr;
    logic                                        w_accept;
    logic                                        w_wrap_wait;
    logic                                        w_sweep_start;
    logic                                        w_busy;
    logic [EW-1:0]                               w_item_epoch;
    logic [EW-1:0]                               w_rd_tag;
    logic                                        w_s1_adv;
    logic                                        w_first;
    logic                                        w_wr_en;
    logic [31:0]                                 w_s1_label_ext;

    logic [EW-1:0]          r_epoch;
    logic                   r_s1_vld;
    logic [LW-1:0]          r_s1_label;
    logic [IW-1:0]          r_s1_index;
    lsef_pkg::t_ring_result r_s1_ring;
    logic                   r_s1_inrange;
    logic [EW-1:0]          r_s1_epoch;
    logic                   r_out_vld;
    logic [OUT_W-1:0]       r_out_data;

    assign w_center      = s_axis_tdata[LW-1:0];
    assign w_neighbors   = s_axis_tdata[MASK_LO-1:NB_LO];
    assign w_inside      = s_axis_tdata[INDEX_LO-1:MASK_LO];
    assign w_index       = s_axis_tdata[INDEX_LO+IW-1:INDEX_LO];
    assign w_frame_start = s_axis_tuser[0];

    lsef_ring_count u_ring (
        .i_center    (w_center),
        .i_neighbors (w_neighbors),
        .i_inside    (w_inside),
        .o_result    (w_ring)
    );

    assign w_label_ext = 32'(w_center);
    assign w_rd_addr   = w_label_ext[AW-1:0];

    assign w_wrap_wait   = s_axis_tvalid && w_frame_start && (r_epoch == lsef_pkg::EPOCH_WRAP);
    assign w_sweep_start = w_wrap_wait && !r_s1_vld && !w_busy;
    assign w_s1_adv      = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !w_busy && !w_wrap_wait && (!r_s1_vld || w_s1_adv);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_item_epoch  = w_frame_start ? r_epoch + EW'(1) : r_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= '0;
        end else if (w_sweep_start) begin
            r_epoch <= lsef_pkg::CLEAR_TAG;
        end else if (w_accept) begin
            r_epoch <= w_item_epoch;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_label   <= w_center;
            r_s1_index   <= w_index;
            r_s1_ring    <= w_ring;
            r_s1_inrange <= (w_label_ext < 32'(MAX_LABELS));
            r_s1_epoch   <= w_item_epoch;
        end
    end

    assign w_s1_label_ext = 32'(r_s1_label);
    assign w_first = r_s1_ring.endpoint && r_s1_inrange && (w_rd_tag != r_s1_epoch);
    assign w_wr_en = w_s1_adv && w_first;

    lsef_seen_store #(
        .MAX_LABELS (MAX_LABELS),
        .AW         (AW)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (w_accept),
        .i_rd_addr     (w_rd_addr),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_s1_label_ext[AW-1:0]),
        .i_wr_tag      (r_s1_epoch),
        .i_sweep_start (w_sweep_start),
        .o_rd_tag      (w_rd_tag),
        .o_busy        (w_busy)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= {w_first, r_s1_ring.endpoint, r_s1_ring.count,
                           r_s1_index, r_s1_label};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_data};

endmodule
`default_nettype wire

// ===== sv/lsef_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsef_checker
// Port-level checks of the endpoint finder, bound to the top level.
// ----------------------------------------------------------------------------
module lsef_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_first_is_endpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[37] |-> m_axis_tdata[36])
        else $error("first endpoint without endpoint flag");

    a_endpoint_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[36] |->
            (m_axis_tdata[35:32] == 4'd1) && (m_axis_tdata[11:0] != 12'd0))
        else $error("endpoint flag with count other than one or background");

    a_background_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[11:0] == 12'd0) |-> (m_axis_tdata[37:32] == 6'd0))
        else $error("background pixel with nonzero result");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("input ready or output valid right after reset");

endmodule

bind labeled_segment_endpoint_finder_core lsef_checker u_lsef_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
